>>> rtl/core/ifla_pkg.sv
// ifla_pkg: shared types and constants for the slot index allocator
// no dependencies; compiled first
`default_nettype none

package ifla_pkg;

    localparam int FUNC_W   = 2;
    localparam int SLOT_W   = 15;
    localparam int STATUS_W = 2;
    // wide enough for any index or count of the largest pool
    localparam int EXT_W    = 17;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ALLOC = 2'd0,
        FUNC_FREE  = 2'd1,
        FUNC_RESET = 2'd2,
        FUNC_NOP   = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_DISABLED = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOT_USED = 2'd3
    } t_status;

    // control from the request sequencer to the used bitmap
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic wr_data;
        logic clear;
    } t_bm_ctl;

endpackage

`default_nettype wire

>>> rtl/core/ifla_if.sv
// ifla_req_if / ifla_rsp_if: valid/ready channels for request and response words
// depends on ifla_pkg
`default_nettype none

interface ifla_req_if
    import ifla_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [SLOT_W-1:0] slot_index;

    modport source (output valid, output func, output slot_index, input ready);
    modport sink   (input valid, input func, input slot_index, output ready);
endinterface

interface ifla_rsp_if
    import ifla_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [SLOT_W-1:0]   granted_index;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output granted_index, output status, input ready);
    modport sink   (input valid, input granted_index, input status, output ready);
endinterface

`default_nettype wire

>>> rtl/core/index_free_list_allocator.sv
// index_free_list_allocator: top level, free index stack memory and request sequencer
// depends on ifla_pkg, ifla_req_if, ifla_rsp_if and ifla_bitmap
`default_nettype none

// Hands out slot indices 0..ENTRIES-1. Free indices sit in a stack memory and a
// used bitmap memory marks every index handed out. The accept cycle reads both
// memories; the execute state then modifies and writes back and loads the
// response register, and stalls while an untaken response is still held. No
// request is taken until the execute state is left, but a new request is
// accepted while the last response still waits. Stack entries below the lowest
// stack depth reached since the last refill read back as their own position,
// so the stack needs no refill pass. The used bitmap is cleared one bit per
// cycle: after reset and after an enabled pool reset request no request is
// accepted until the sweep ends, while the enable register can still be written.

module index_free_list_allocator
    import ifla_pkg::*;
#(
    parameter int  ENTRIES = 32768,
    localparam int IDX_W   = $clog2(ENTRIES),
    localparam int CNT_W   = $clog2(ENTRIES + 1)
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cfg_wr_en,
    input  wire logic i_cfg_wr_data,
    ifla_req_if.sink  i_req,
    ifla_rsp_if.source o_rsp
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state           r_state;
    logic             r_enable;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_mark;
    logic             r_out_valid;
    logic [SLOT_W-1:0] r_granted;
    t_status          r_status;

    t_func            r_func;
    logic [SLOT_W-1:0] r_slot;
    logic [IDX_W-1:0] r_pos;
    logic             r_virgin;
    logic [IDX_W-1:0] r_stk_rdata;
    logic [IDX_W-1:0] r_stack [ENTRIES];

    logic             accept;
    logic             out_free;
    logic             exec_fire;
    logic [CNT_W-1:0] pos_full;
    logic [EXT_W-1:0] in_slot_ext;
    logic [EXT_W-1:0] slot_ext;
    logic [IDX_W-1:0] slot_addr;
    logic [IDX_W-1:0] v_idx;
    logic [EXT_W-1:0] v_ext;
    logic             alloc_ok;
    logic             free_ok;
    logic [SLOT_W-1:0] res_granted;
    t_status          res_status;
    logic             stk_we;
    logic             bm_we;
    logic             bm_wdata;
    logic [IDX_W-1:0] bm_waddr;
    logic             cnt_dec;
    logic             cnt_inc;
    logic             refill;
    logic             bm_rdata;
    logic             bm_busy;
    t_bm_ctl          bm_ctl;

    assign i_req.ready = (r_state == S_IDLE) && !bm_busy;
    assign accept      = i_req.valid && i_req.ready;
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign exec_fire   = (r_state == S_EXEC) && out_free;
    assign pos_full    = r_count - 1'b1;
    assign in_slot_ext = EXT_W'(i_req.slot_index);

    always_comb begin
        slot_ext    = EXT_W'(r_slot);
        slot_addr   = slot_ext[IDX_W-1:0];
        v_idx       = r_virgin ? r_pos : r_stk_rdata;
        v_ext       = EXT_W'(v_idx);
        alloc_ok    = (r_count != '0);
        free_ok     = (slot_ext < EXT_W'(ENTRIES)) && bm_rdata
                      && (r_count < CNT_W'(ENTRIES));
        res_granted = '0;
        res_status  = ST_OK;
        stk_we      = 1'b0;
        bm_we       = 1'b0;
        bm_wdata    = 1'b0;
        bm_waddr    = slot_addr;
        cnt_dec     = 1'b0;
        cnt_inc     = 1'b0;
        refill      = 1'b0;
        if (!r_enable) begin
            res_status = ST_DISABLED;
        end else begin
            unique case (r_func)
                FUNC_ALLOC: begin
                    if (alloc_ok) begin
                        res_granted = v_ext[SLOT_W-1:0];
                        bm_we       = 1'b1;
                        bm_wdata    = 1'b1;
                        bm_waddr    = v_idx;
                        cnt_dec     = 1'b1;
                    end else begin
                        res_status = ST_EMPTY;
                    end
                end
                FUNC_FREE: begin
                    if (free_ok) begin
                        stk_we  = 1'b1;
                        bm_we   = 1'b1;
                        cnt_inc = 1'b1;
                    end else begin
                        res_status = ST_NOT_USED;
                    end
                end
                FUNC_RESET: begin
                    refill = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        bm_ctl.rd_en   = accept;
        bm_ctl.wr_en   = exec_fire && bm_we;
        bm_ctl.wr_data = bm_wdata;
        bm_ctl.clear   = exec_fire && refill;
    end

    ifla_bitmap #(
        .ENTRIES (ENTRIES)
    ) u_bitmap (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (bm_ctl),
        .i_rd_addr (in_slot_ext[IDX_W-1:0]),
        .i_wr_addr (bm_waddr),
        .o_rd_data (bm_rdata),
        .o_busy    (bm_busy)
    );

    // stack memory and request word
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func      <= t_func'(i_req.func);
            r_slot      <= i_req.slot_index;
            r_pos       <= pos_full[IDX_W-1:0];
            r_virgin    <= pos_full < r_mark;
            r_stk_rdata <= r_stack[pos_full[IDX_W-1:0]];
        end
        if (exec_fire && stk_we) begin
            r_stack[r_count[IDX_W-1:0]] <= slot_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_enable    <= 1'b0;
            r_count     <= CNT_W'(ENTRIES);
            r_mark      <= CNT_W'(ENTRIES);
            r_out_valid <= 1'b0;
            r_granted   <= '0;
            r_status    <= ST_OK;
        end else begin
            if (i_cfg_wr_en) begin
                r_enable <= i_cfg_wr_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (exec_fire) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (exec_fire) begin
                r_out_valid <= 1'b1;
                r_granted   <= res_granted;
                r_status    <= res_status;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (exec_fire) begin
                if (refill) begin
                    r_count <= CNT_W'(ENTRIES);
                    r_mark  <= CNT_W'(ENTRIES);
                end else if (cnt_dec) begin
                    r_count <= pos_full;
                    if (r_virgin) begin
                        r_mark <= pos_full;
                    end
                end else if (cnt_inc) begin
                    r_count <= r_count + 1'b1;
                end
            end
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.granted_index = r_granted;
    assign o_rsp.status        = r_status;

endmodule

`default_nettype wire

>>> rtl/core/ifla_bitmap.sv
// ifla_bitmap: used bitmap memory, one bit per slot, with a clearing sweep
// depends on ifla_pkg
`default_nettype none

module ifla_bitmap
    import ifla_pkg::*;
#(
    parameter int  ENTRIES = 32768,
    localparam int IDX_W   = $clog2(ENTRIES)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_bm_ctl          i_ctl,
    input  wire logic [IDX_W-1:0] i_rd_addr,
    input  wire logic [IDX_W-1:0] i_wr_addr,
    output logic                  o_rd_data,
    output logic                  o_busy
);

    logic             r_map [ENTRIES];
    logic             r_rd_data;
    logic             r_busy;
    logic [IDX_W-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (i_ctl.clear) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            if (r_clr_addr == IDX_W'(ENTRIES - 1)) begin
                r_busy <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_map[r_clr_addr] <= 1'b0;
        end else if (i_ctl.wr_en) begin
            r_map[i_wr_addr] <= i_ctl.wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_map[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_busy;

endmodule

`default_nettype wire
